[rtl/watershed_level_flood_label_assert.svh]
// Assertion macros used by the checker file.
`ifndef WATERSHED_LEVEL_FLOOD_LABEL_ASSERT_SVH
`define WATERSHED_LEVEL_FLOOD_LABEL_ASSERT_SVH
// Implication checked at every clock edge outside reset.
`define WLF_ASSERT_IMPL(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);
// Next-cycle implication.
`define WLF_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);
`endif

[rtl/wlf_pkg.sv]
// ----------------------------------------------------------------------------
// wlf_pkg
// Types and constants shared by the watershed labeling block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package wlf_pkg;
    localparam int LABEL_W = 18;
    localparam int REGION_W = 17;
    localparam logic [REGION_W-1:0] REGION_LIMIT = 17'h1FFFF;
    localparam logic signed [LABEL_W-1:0] LABEL_UNKNOWN = -18'sd1;
    localparam logic [1:0] REG_ROWS = 2'd0;
    localparam logic [1:0] REG_COLS = 2'd1;
    localparam logic [1:0] REG_CONN = 2'd2;
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_RD_WAIT, S_RD_OUT,
        S_LBL_CLR, S_SCAN_ISSUE, S_SCAN_WAIT, S_NB_ISSUE, S_NB_WAIT, S_WRITE
    } t_state;

    // Commands from controller to datapath.
    typedef struct packed {
        logic load_pix;     // store input pixel, advance load position
        logic rd_issue;     // issue label read at request position
        logic rd_capture;   // latch result label
        logic clr_start;    // reset clear counter
        logic clr_step;     // clear one label entry
        logic scan_start;   // begin labeling: level = 0, pos = 0
        logic scan_next;    // advance scan position / level
        logic nb_start;     // begin neighbour walk
        logic nb_issue;     // read label of current neighbour
        logic nb_accum;     // fold returned neighbour label
        logic lbl_write;    // write label of current pixel
        logic lbl_done;     // reset load position
    } t_cmd;

    typedef struct packed {
        logic clr_done;
        logic pix_match;    // scanned pixel equals current level
        logic scan_last;    // last position of last level
        logic nb_valid;     // current neighbour is in bounds
        logic nb_last;      // current neighbour is the eighth
        logic conn;
    } t_stat;
endpackage
`default_nettype wire

[rtl/watershed_level_flood_label.sv]
// ----------------------------------------------------------------------------
// watershed_level_flood_label
// Watershed labeling of an 8-bit image by grey-level flooding.
// ----------------------------------------------------------------------------
// After reset a clearing pass sets every label to unknown before the first
// request is accepted. A load stores one pixel; a read issues the label
// address, captures the label and holds the result until it is taken. The
// last pixel starts labeling: a clear pass, then 256 raster scans through the
// single pixel RAM port, with eight neighbour reads through the label RAM port
// per matching pixel when connectivity is on, and one write per labeled pixel.
// Configuration writes are accepted only while the block is idle.
`timescale 1ns / 1ps
`default_nettype none
module watershed_level_flood_label
    import wlf_pkg::*;
#(
    parameter int ROWS_MAX = 256,
    parameter int COLS_MAX = 256
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire logic                 i_op,
    input  wire logic [7:0]           i_pixel,
    input  wire logic                 i_last,
    input  wire logic [7:0]           i_row,
    input  wire logic [7:0]           i_col,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output logic signed [LABEL_W-1:0] o_label,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [1:0]           i_cfg_index,
    input  wire logic [8:0]           i_cfg_data
);
    t_cmd  w_cmd;
    t_stat w_stat;
    logic  w_idle;

    assign o_cfg_ready = w_idle;

    wlf_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_op(i_op),
        .i_last(i_last), .o_ready(o_ready), .o_valid(o_valid), .i_ready(i_ready),
        .o_idle(w_idle), .i_stat(w_stat), .o_cmd(w_cmd)
    );

    wlf_datapath #(.ROWS_MAX(ROWS_MAX), .COLS_MAX(COLS_MAX)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .o_stat(w_stat),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_pixel(i_pixel), .i_row(i_row), .i_col(i_col), .o_label(o_label)
    );
endmodule
`default_nettype wire

[rtl/wlf_ram.sv]
// ----------------------------------------------------------------------------
// wlf_ram
// Single-port RAM with registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module wlf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

[rtl/wlf_ctrl.sv]
// ----------------------------------------------------------------------------
// wlf_ctrl
// Sequencer for load, read, clear and flood labeling.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module wlf_ctrl
    import wlf_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    input  wire logic  i_op,
    input  wire logic  i_last,
    output logic       o_ready,
    output logic       o_valid,
    input  wire logic  i_ready,
    output logic       o_idle,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd
);
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_ready = 1'b0;
        o_valid = 1'b0;
        o_idle = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_ready = 1'b1;
                o_idle = 1'b1;
                if (i_valid) begin
                    if (i_op == OP_READ) begin
                        // The read address is taken while the request is still on the port.
                        o_cmd.rd_issue = 1'b1;
                        n_state = S_RD_WAIT;
                    end else begin
                        o_cmd.load_pix = 1'b1;
                        if (i_last) begin
                            o_cmd.clr_start = 1'b1;
                            n_state = S_LBL_CLR;
                        end
                    end
                end
            end
            S_RD_WAIT: begin
                o_cmd.rd_capture = 1'b1;
                n_state = S_RD_OUT;
            end
            S_RD_OUT: begin
                o_valid = 1'b1;
                if (i_ready) begin
                    n_state = S_IDLE;
                end
            end
            S_LBL_CLR: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.clr_done) begin
                    o_cmd.scan_start = 1'b1;
                    n_state = S_SCAN_ISSUE;
                end
            end
            S_SCAN_ISSUE: begin
                n_state = S_SCAN_WAIT;
            end
            S_SCAN_WAIT: begin
                if (i_stat.pix_match) begin
                    o_cmd.nb_start = 1'b1;
                    n_state = i_stat.conn ? S_NB_ISSUE : S_WRITE;
                end else if (i_stat.scan_last) begin
                    o_cmd.lbl_done = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    o_cmd.scan_next = 1'b1;
                    n_state = S_SCAN_ISSUE;
                end
            end
            S_NB_ISSUE: begin
                o_cmd.nb_issue = 1'b1;
                n_state = S_NB_WAIT;
            end
            S_NB_WAIT: begin
                o_cmd.nb_accum = 1'b1;
                n_state = i_stat.nb_last ? S_WRITE : S_NB_ISSUE;
            end
            S_WRITE: begin
                o_cmd.lbl_write = 1'b1;
                if (i_stat.scan_last) begin
                    o_cmd.lbl_done = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    o_cmd.scan_next = 1'b1;
                    n_state = S_SCAN_ISSUE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule
`default_nettype wire

[rtl/wlf_datapath.sv]
// ----------------------------------------------------------------------------
// wlf_datapath
// Frame counters, neighbour walk, region counter and the two image stores.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module wlf_datapath
    import wlf_pkg::*;
#(
    parameter int ROWS_MAX = 256,
    parameter int COLS_MAX = 256
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire t_cmd                      i_cmd,
    output t_stat                          o_stat,
    input  wire logic                      i_cfg_valid,
    input  wire logic                      i_cfg_ready,
    input  wire logic [1:0]                i_cfg_index,
    input  wire logic [8:0]                i_cfg_data,
    input  wire logic [7:0]                i_pixel,
    input  wire logic [7:0]                i_row,
    input  wire logic [7:0]                i_col,
    output logic signed [LABEL_W-1:0]      o_label
);
    localparam int RW = $clog2(ROWS_MAX);
    localparam int CW = $clog2(COLS_MAX);
    localparam int NPIX = ROWS_MAX * COLS_MAX;
    localparam int AW = $clog2(NPIX);
    localparam int DW = (RW > CW ? RW : CW) + 2;

    logic [8:0] r_rows_cfg, r_cols_cfg;
    logic       r_conn;
    logic [DW-1:0] w_nr, w_nc;
    logic [AW:0]   w_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_cfg <= 9'd256;
            r_cols_cfg <= 9'd256;
            r_conn <= 1'b1;
        end else if (i_cfg_valid && i_cfg_ready) begin
            case (i_cfg_index)
                REG_ROWS: r_rows_cfg <= i_cfg_data;
                REG_COLS: r_cols_cfg <= i_cfg_data;
                REG_CONN: r_conn <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_rows_cfg == 9'd0) w_nr = DW'(1);
        else if (DW'(r_rows_cfg) > DW'(ROWS_MAX)) w_nr = DW'(ROWS_MAX);
        else w_nr = DW'(r_rows_cfg);
        if (r_cols_cfg == 9'd0) w_nc = DW'(1);
        else if (DW'(r_cols_cfg) > DW'(COLS_MAX)) w_nc = DW'(COLS_MAX);
        else w_nc = DW'(r_cols_cfg);
    end
    assign w_n = (AW+1)'(w_nr * w_nc);

    // Load position.
    logic [AW:0] r_load_pos;
    logic [AW:0] w_load_wr;
    assign w_load_wr = (r_load_pos >= w_n) ? '0 : r_load_pos;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.lbl_done) begin
            r_load_pos <= '0;
        end else if (i_cmd.load_pix) begin
            r_load_pos <= w_load_wr + 1'b1;
        end
    end

    // Clear counter over every label entry.
    logic [AW:0] r_clr;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clr_start) begin
            r_clr <= '0;
        end else if (i_cmd.clr_step) begin
            r_clr <= r_clr + 1'b1;
        end
    end
    assign o_stat.clr_done = (r_clr == (AW+1)'(NPIX - 1));

    // Scan position, kept as row/column to avoid any division.
    logic [7:0]    r_level;
    logic [DW-1:0] r_sr, r_sc;
    logic [AW:0]   r_spos;
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_start) begin
            r_level <= '0;
            r_sr <= '0;
            r_sc <= '0;
            r_spos <= '0;
        end else if (i_cmd.scan_next) begin
            if (r_spos == w_n - 1'b1) begin
                r_level <= r_level + 1'b1;
                r_sr <= '0;
                r_sc <= '0;
                r_spos <= '0;
            end else begin
                r_spos <= r_spos + 1'b1;
                if (r_sc == w_nc - 1'b1) begin
                    r_sc <= '0;
                    r_sr <= r_sr + 1'b1;
                end else begin
                    r_sc <= r_sc + 1'b1;
                end
            end
        end
    end
    assign o_stat.scan_last = (r_spos == w_n - 1'b1) && (r_level == 8'hFF);
    assign o_stat.conn = r_conn;

    // Neighbour walk over the eight offsets.
    logic [2:0] r_nb;
    logic signed [DW:0] w_dr, w_dc, w_rr, w_cc;
    logic signed [AW+1:0] w_naddr;
    always_comb begin
        case (r_nb)
            3'd0: begin w_dr = '1; w_dc = '1; end
            3'd1: begin w_dr = '1; w_dc = '0; end
            3'd2: begin w_dr = '1; w_dc = (DW+1)'(1); end
            3'd3: begin w_dr = '0; w_dc = '1; end
            3'd4: begin w_dr = '0; w_dc = (DW+1)'(1); end
            3'd5: begin w_dr = (DW+1)'(1); w_dc = '1; end
            3'd6: begin w_dr = (DW+1)'(1); w_dc = '0; end
            default: begin w_dr = (DW+1)'(1); w_dc = (DW+1)'(1); end
        endcase
        w_rr = $signed({1'b0, r_sr}) + w_dr;
        w_cc = $signed({1'b0, r_sc}) + w_dc;
        w_naddr = $signed({1'b0, r_spos}) + (AW+2)'(w_dr * $signed({1'b0, w_nc})) +
                  (AW+2)'(w_dc);
    end
    assign o_stat.nb_valid = (w_rr >= 0) && (w_rr < $signed({1'b0, w_nr})) &&
                             (w_cc >= 0) && (w_cc < $signed({1'b0, w_nc}));
    assign o_stat.nb_last = (r_nb == 3'd7);

    logic r_nb_vld;
    logic signed [LABEL_W-1:0] r_st;
    always_ff @(posedge i_clk) begin
        if (i_cmd.nb_start) begin
            r_nb <= '0;
        end else if (i_cmd.nb_accum) begin
            r_nb <= r_nb + 1'b1;
        end
        if (i_cmd.nb_issue) begin
            r_nb_vld <= o_stat.nb_valid;
        end
    end

    // Stores.
    logic [AW-1:0] w_paddr, w_laddr;
    logic          w_lwe;
    logic signed [LABEL_W-1:0] w_lwdata, w_lrdata;
    logic [7:0]    w_prdata;
    logic [REGION_W-1:0] r_next;
    logic [AW:0] w_rd_addr;

    assign w_rd_addr = (AW+1)'(i_row) * (AW+1)'(w_nc) + (AW+1)'(i_col);
    assign w_paddr = i_cmd.load_pix ? w_load_wr[AW-1:0] : r_spos[AW-1:0];

    always_comb begin
        w_lwe = 1'b0;
        w_lwdata = LABEL_UNKNOWN;
        w_laddr = r_spos[AW-1:0];
        if (i_cmd.clr_step) begin
            w_lwe = 1'b1;
            w_laddr = r_clr[AW-1:0];
        end else if (i_cmd.lbl_write) begin
            w_lwe = 1'b1;
            w_lwdata = (r_st >= 0) ? r_st : $signed({1'b0, r_next});
        end else if (i_cmd.nb_issue) begin
            w_laddr = w_naddr[AW-1:0];
        end else if (i_cmd.rd_issue) begin
            w_laddr = w_rd_addr[AW-1:0];
        end
    end

    wlf_ram #(.WIDTH(8), .DEPTH(NPIX)) u_pix (
        .i_clk(i_clk), .i_we(i_cmd.load_pix), .i_addr(w_paddr),
        .i_wdata(i_pixel), .o_rdata(w_prdata)
    );
    wlf_ram #(.WIDTH(LABEL_W), .DEPTH(NPIX)) u_lbl (
        .i_clk(i_clk), .i_we(w_lwe), .i_addr(w_laddr),
        .i_wdata(w_lwdata), .o_rdata(w_lrdata)
    );

    assign o_stat.pix_match = (w_prdata == r_level);

    always_ff @(posedge i_clk) begin
        if (i_cmd.nb_start) begin
            r_st <= LABEL_UNKNOWN;
        end else if (i_cmd.nb_accum && r_nb_vld && (w_lrdata > 0)) begin
            if (r_st == LABEL_UNKNOWN) r_st <= w_lrdata;
            else if (w_lrdata != r_st) r_st <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clr_start) begin
            r_next <= REGION_W'(1);
        end else if (i_cmd.lbl_write && r_st < 0 && r_next != REGION_LIMIT) begin
            r_next <= r_next + 1'b1;
        end
    end

    logic r_rd_in;
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_issue) begin
            r_rd_in <= (DW'(i_row) < w_nr) && (DW'(i_col) < w_nc);
        end
        if (i_cmd.rd_capture) begin
            o_label <= r_rd_in ? w_lrdata : LABEL_UNKNOWN;
        end
    end
endmodule
`default_nettype wire

[rtl/wlf_checker.sv]
// ----------------------------------------------------------------------------
// wlf_checker
// Port-level checks on the watershed labeling block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "watershed_level_flood_label_assert.svh"
module wlf_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_ready,
    input wire logic        i_op,
    input wire logic        o_valid,
    input wire logic        i_ready,
    input wire logic [17:0] o_label
);
    // A result never overlaps acceptance of a new request.
    `WLF_ASSERT_IMPL(a_no_overlap, i_clk, i_rst_n, o_valid, !o_ready, "ready while result pending")
    // A load never produces a result.
    `WLF_ASSERT_NEXT(a_load_silent, i_clk, i_rst_n, i_valid && o_ready && !i_op, !o_valid, "load made result")
    // A stalled result keeps its label.
    `WLF_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_label), "result changed")
endmodule
bind watershed_level_flood_label wlf_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
    .i_op(i_op), .o_valid(o_valid), .i_ready(i_ready), .o_label(o_label)
);
`default_nettype wire
